FILE: src/lbp_pkg.sv
// ----------------------------------------------------------------------------
// lbp_pkg
// Types and constants shared by the 3x3 local binary pattern blocks.
// ----------------------------------------------------------------------------
package lbp_pkg;

    localparam int PIX_W      = 8;
    localparam int CODE_W     = 8;
    localparam int ROW_OUT_W  = 12;
    localparam int COL_OUT_W  = 10;
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 13;
    localparam int NUM_NB     = 8;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(640);
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(480);

    // Output queue sizing.
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = 2;
    localparam int OUT_CNT_W = 3;

    // One column of the 3x3 window, top row first.
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } t_column;

    typedef struct packed {
        logic [CODE_W-1:0]    code;
        logic [ROW_OUT_W-1:0] row;
        logic [COL_OUT_W-1:0] col;
        logic                 done;
    } t_result;

endpackage

FILE: src/lbp_ram.sv
// ----------------------------------------------------------------------------
// lbp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lbp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/lbp_window.sv
// ----------------------------------------------------------------------------
// lbp_window
// Holds the two older columns of the 3x3 window and compares the eight
// neighbors against the center as the newest column arrives.
// ----------------------------------------------------------------------------
module lbp_window (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_shift,
    input  lbp_pkg::t_column             i_col,
    output logic [lbp_pkg::CODE_W-1:0]   o_code
);
    import lbp_pkg::*;

    t_column              r_col0;
    t_column              r_col1;
    logic [PIX_W-1:0]     w_nb [NUM_NB];
    logic [PIX_W-1:0]     w_center;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col0 <= '0;
            r_col1 <= '0;
        end else if (i_shift) begin
            r_col0 <= r_col1;
            r_col1 <= i_col;
        end
    end

    // Neighbor order: top-left, top, top-right, left, right,
    // bottom-left, bottom, bottom-right.
    always_comb begin
        w_center = r_col1.mid;
        w_nb[0]  = r_col0.top;
        w_nb[1]  = r_col1.top;
        w_nb[2]  = i_col.top;
        w_nb[3]  = r_col0.mid;
        w_nb[4]  = i_col.mid;
        w_nb[5]  = r_col0.bot;
        w_nb[6]  = r_col1.bot;
        w_nb[7]  = i_col.bot;
        for (int k = 0; k < NUM_NB; k++) begin
            o_code[k] = (w_nb[k] > w_center);
        end
    end

endmodule

FILE: src/lbp_out_fifo.sv
// ----------------------------------------------------------------------------
// lbp_out_fifo
// Small register queue that holds finished codes until the consumer takes
// them, so the pipeline keeps running while the output is stalled.
// ----------------------------------------------------------------------------
module lbp_out_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  lbp_pkg::t_result              i_data,
    input  logic                          i_ready,
    output logic                          o_valid,
    output lbp_pkg::t_result              o_data,
    output logic [lbp_pkg::OUT_CNT_W-1:0] o_count
);
    import lbp_pkg::*;

    t_result                r_mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]   r_wr_ptr;
    logic [OUT_PTR_W-1:0]   r_rd_ptr;
    logic [OUT_CNT_W-1:0]   r_count;
    logic                   w_pop;

    assign o_valid = (r_count != '0);
    assign w_pop   = o_valid && i_ready;
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + OUT_PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + OUT_PTR_W'(1);
            end
            r_count <= r_count + OUT_CNT_W'(i_push) - OUT_CNT_W'(w_pop);
        end
    end

endmodule

FILE: src/lbp_3x3_pixel_stream.sv
// ----------------------------------------------------------------------------
// lbp_3x3_pixel_stream
// 3x3 local binary pattern over a raster-order 8-bit grayscale stream.
// The block takes one pixel per clock with no gaps of its own making. Each
// pixel transfer issues a read of the line RAM, which holds the two previous
// rows side by side in one word; the next cycle the word returns, the window
// shifts in the new column, the eight comparisons are made and the column is
// written back. Finished codes pass through a four-entry queue that lets input
// keep flowing while the output is briefly held. Border pixels give no code.
// Writing either frame register restarts the frame at row 0, column 0; the
// line RAM needs no clearing after reset.
// ----------------------------------------------------------------------------
module lbp_3x3_pixel_stream #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // pixel input
    input  logic                              i_pixel_valid,
    output logic                              o_pixel_ready,
    input  logic [lbp_pkg::PIX_W-1:0]         i_pixel_value,
    // result output
    output logic                              o_result_valid,
    input  logic                              i_result_ready,
    output logic [lbp_pkg::CODE_W-1:0]        o_pattern_code,
    output logic [lbp_pkg::ROW_OUT_W-1:0]     o_center_row,
    output logic [lbp_pkg::COL_OUT_W-1:0]     o_center_col,
    output logic                              o_frame_done,
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lbp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lbp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import lbp_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int LW = 2 * PIX_W;

    logic [FW_W-1:0]      r_frame_width;
    logic [FH_W-1:0]      r_frame_height;
    logic [CW-1:0]        w_last_col;
    logic [RW-1:0]        w_last_row;

    logic [CW-1:0]        r_col;
    logic [RW-1:0]        r_row;
    logic [CW-1:0]        n_col;
    logic [RW-1:0]        n_row;

    logic                 w_in_fire;
    logic                 w_cfg_fire;
    logic                 w_cfg_hit;

    logic                 r_s1_valid;
    logic                 r_s1_emit;
    logic [PIX_W-1:0]     r_s1_px;
    logic [CW-1:0]        r_s1_col;
    t_result              r_s1_info;

    logic [LW-1:0]        w_line_rd;
    t_column              w_new_col;
    logic [CODE_W-1:0]    w_code;
    t_result              w_push_data;
    logic                 w_push;

    t_result              w_out;
    logic [OUT_CNT_W-1:0] w_fifo_count;
    logic [OUT_CNT_W-1:0] w_inflight;

    // Effective frame size, saturated to the supported range.
    always_comb begin
        if (r_frame_width < FW_W'(3)) begin
            w_last_col = CW'(2);
        end else if (int'(r_frame_width) > MAX_WIDTH) begin
            w_last_col = CW'(MAX_WIDTH - 1);
        end else begin
            w_last_col = CW'(r_frame_width - FW_W'(1));
        end
        if (r_frame_height < FH_W'(3)) begin
            w_last_row = RW'(2);
        end else if (int'(r_frame_height) > MAX_HEIGHT) begin
            w_last_row = RW'(MAX_HEIGHT - 1);
        end else begin
            w_last_row = RW'(r_frame_height - FH_W'(1));
        end
    end

    assign o_cfg_ready = 1'b1;
    assign w_cfg_fire  = i_cfg_valid && o_cfg_ready;
    assign w_cfg_hit   = w_cfg_fire &&
                         ((i_cfg_index == CFG_FRAME_WIDTH) ||
                          (i_cfg_index == CFG_FRAME_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (w_cfg_fire) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[FW_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[FH_W-1:0];
                default:          ;
            endcase
        end
    end

    // Room is kept in the queue for every item already in the pipeline.
    assign w_inflight    = w_fifo_count + OUT_CNT_W'(r_s1_valid);
    assign o_pixel_ready = (w_inflight <= OUT_CNT_W'(OUT_DEPTH - 2));
    assign w_in_fire     = i_pixel_valid && o_pixel_ready;

    always_comb begin
        n_col = r_col + CW'(1);
        n_row = r_row;
        if (r_col == w_last_col) begin
            n_col = '0;
            n_row = (r_row == w_last_row) ? '0 : r_row + RW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_cfg_hit) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_in_fire) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Read stage: the line RAM word for this column is fetched.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_in_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1_px        <= i_pixel_value;
            r_s1_col       <= r_col;
            r_s1_emit      <= (r_row >= RW'(2)) && (r_col >= CW'(2));
            r_s1_info.code <= '0;
            r_s1_info.row  <= ROW_OUT_W'(r_row - RW'(1));
            r_s1_info.col  <= COL_OUT_W'(r_col - CW'(1));
            r_s1_info.done <= (r_row == w_last_row) && (r_col == w_last_col);
        end
    end

    // RAM word: upper line in the high byte, middle line in the low byte.
    lbp_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata ({w_line_rd[PIX_W-1:0], r_s1_px}),
        .i_re    (w_in_fire),
        .i_raddr (r_col),
        .o_rdata (w_line_rd)
    );

    assign w_new_col.top = w_line_rd[LW-1:PIX_W];
    assign w_new_col.mid = w_line_rd[PIX_W-1:0];
    assign w_new_col.bot = r_s1_px;

    lbp_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (r_s1_valid),
        .i_col   (w_new_col),
        .o_code  (w_code)
    );

    always_comb begin
        w_push_data      = r_s1_info;
        w_push_data.code = w_code;
    end
    assign w_push = r_s1_valid && r_s1_emit;

    lbp_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_ready (i_result_ready),
        .o_valid (o_result_valid),
        .o_data  (w_out),
        .o_count (w_fifo_count)
    );

    assign o_pattern_code = w_out.code;
    assign o_center_row   = w_out.row;
    assign o_center_col   = w_out.col;
    assign o_frame_done   = w_out.done;

`ifndef ASSERT_OFF
    // A code is only pushed when the queue has a free entry or one leaves.
    a_queue_room : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (w_fifo_count != OUT_CNT_W'(OUT_DEPTH)) ||
                   (o_result_valid && i_result_ready))
        else $error("output queue overflow");

    // The position counters stay inside the effective frame.
    a_pos_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col <= w_last_col) && (r_row <= w_last_row))
        else $error("position counter out of frame");

    // The write-back never targets the column being read in the same cycle.
    a_no_collide : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && w_in_fire) |-> (r_s1_col != r_col))
        else $error("line RAM read and write-back collide");
`endif

endmodule
